/* src/ble_pkg.sv */
// Shared types and constants for the boolean expression lexer.
// Used by ble_front, ble_queue, ble_back and the top level; no dependencies.
package ble_pkg;

  localparam int VALUE_BITS     = 32;
  localparam int POS_BITS       = 16;
  localparam int ACC_EXT_BITS   = VALUE_BITS + 4;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] KW_INPUT_LEN  = 3'd5;
  localparam logic [2:0] KW_OUTPUT_LEN = 3'd6;
  localparam logic [2:0] NAME_LEN_MAX  = 3'd7;

  localparam logic [7:0] CHAR_EQUAL = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  typedef enum logic [3:0] {
    KIND_KW_INPUT  = 4'd0,
    KIND_KW_OUTPUT = 4'd1,
    KIND_NAME      = 4'd2,
    KIND_INTEGER   = 4'd3,
    KIND_EQUAL     = 4'd4,
    KIND_PLUS      = 4'd5,
    KIND_STAR      = 4'd6,
    KIND_TILDE     = 4'd7,
    KIND_SEMI      = 4'd8,
    KIND_OTHER     = 4'd9
  } token_kind_e;

  // One queue entry: the flushed name/integer token (a) and the token the
  // character itself gives (b). Either may be absent.
  typedef struct packed {
    logic                  a_valid;
    token_kind_e           a_kind;
    logic [VALUE_BITS-1:0] a_value;
    logic                  a_ovf;
    logic [POS_BITS-1:0]   a_start;
    logic                  b_valid;
    token_kind_e           b_kind;
    logic [POS_BITS-1:0]   b_start;
    logic                  b_end;
  } tok_entry_t;

  function automatic logic [7:0] kw_input_char(logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h69; // i
      3'd1:    ch = 8'h6E; // n
      3'd2:    ch = 8'h70; // p
      3'd3:    ch = 8'h75; // u
      3'd4:    ch = 8'h74; // t
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] kw_output_char(logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h6F; // o
      3'd1:    ch = 8'h75; // u
      3'd2:    ch = 8'h74; // t
      3'd3:    ch = 8'h70; // p
      3'd4:    ch = 8'h75; // u
      3'd5:    ch = 8'h74; // t
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

/* src/ble_front.sv */
// Front end: accepts characters, classifies them and tracks the pending token.
// Depends on ble_pkg; pushes token entries into ble_queue.
module ble_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          char_code_i,
  input  logic                end_of_input_i,
  input  logic                queue_full_i,
  output logic                push_o,
  output ble_pkg::tok_entry_t push_data_o
);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NAME = 2'd1,
    MODE_INT  = 2'd2
  } scan_mode_e;

  scan_mode_e                      mode_q, mode_d;
  logic                            in_match_q, in_match_d;
  logic                            out_match_q, out_match_d;
  logic [2:0]                      len_q, len_d;
  logic [ble_pkg::VALUE_BITS-1:0]  acc_q, acc_d;
  logic                            ovf_q, ovf_d;
  logic [ble_pkg::POS_BITS-1:0]    cnt_q, cnt_d;
  logic [ble_pkg::POS_BITS-1:0]    start_q, start_d;

  logic                            accept;
  logic                            is_alpha, is_digit, is_space;
  logic [3:0]                      digit;
  logic [ble_pkg::ACC_EXT_BITS-1:0] acc_ext, acc_times10;
  logic                            name_in_ok, name_out_ok;
  ble_pkg::token_kind_e            flush_kind, op_kind;
  ble_pkg::tok_entry_t             entry;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_alpha = (char_code_i >= 8'h61 && char_code_i <= 8'h7A) ||
                    (char_code_i >= 8'h41 && char_code_i <= 8'h5A);
  assign is_digit = (char_code_i >= 8'h30 && char_code_i <= 8'h39);
  assign is_space = (char_code_i == 8'h20) ||
                    (char_code_i >= 8'h09 && char_code_i <= 8'h0D);

  assign digit = 4'(char_code_i - ble_pkg::CHAR_ZERO);

  // acc*10 + d in a widened word; any bit above VALUE_BITS means overflow
  assign acc_ext     = ble_pkg::ACC_EXT_BITS'(acc_q);
  assign acc_times10 = (acc_ext << 3) + (acc_ext << 1) + ble_pkg::ACC_EXT_BITS'(digit);

  assign name_in_ok  = (len_q < ble_pkg::KW_INPUT_LEN) &&
                       (char_code_i == ble_pkg::kw_input_char(len_q));
  assign name_out_ok = (len_q < ble_pkg::KW_OUTPUT_LEN) &&
                       (char_code_i == ble_pkg::kw_output_char(len_q));

  always_comb begin
    flush_kind = ble_pkg::KIND_NAME;
    if (mode_q == MODE_INT) begin
      flush_kind = ble_pkg::KIND_INTEGER;
    end else if (in_match_q && len_q == ble_pkg::KW_INPUT_LEN) begin
      flush_kind = ble_pkg::KIND_KW_INPUT;
    end else if (out_match_q && len_q == ble_pkg::KW_OUTPUT_LEN) begin
      flush_kind = ble_pkg::KIND_KW_OUTPUT;
    end
  end

  always_comb begin
    case (char_code_i)
      ble_pkg::CHAR_EQUAL: op_kind = ble_pkg::KIND_EQUAL;
      ble_pkg::CHAR_PLUS:  op_kind = ble_pkg::KIND_PLUS;
      ble_pkg::CHAR_STAR:  op_kind = ble_pkg::KIND_STAR;
      ble_pkg::CHAR_TILDE: op_kind = ble_pkg::KIND_TILDE;
      ble_pkg::CHAR_SEMI:  op_kind = ble_pkg::KIND_SEMI;
      default:             op_kind = ble_pkg::KIND_OTHER;
    endcase
  end

  always_comb begin
    mode_d      = mode_q;
    in_match_d  = in_match_q;
    out_match_d = out_match_q;
    len_d       = len_q;
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    cnt_d       = cnt_q;
    start_d     = start_q;

    entry         = '0;
    entry.a_kind  = flush_kind;
    entry.a_value = (mode_q == MODE_INT) ? acc_q : '0;
    entry.a_ovf   = (mode_q == MODE_INT) ? ovf_q : 1'b0;
    entry.a_start = start_q;
    entry.b_kind  = op_kind;
    entry.b_start = cnt_q;

    if (accept) begin
      if (end_of_input_i) begin
        entry.a_valid = (mode_q != MODE_IDLE);
        entry.b_valid = 1'b1;
        entry.b_kind  = ble_pkg::KIND_OTHER;
        entry.b_end   = 1'b1;
        mode_d        = MODE_IDLE;
        in_match_d    = 1'b0;
        out_match_d   = 1'b0;
        len_d         = '0;
        acc_d         = '0;
        ovf_d         = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
        if (mode_q == MODE_NAME && (is_alpha || is_digit)) begin
          in_match_d  = in_match_q && name_in_ok;
          out_match_d = out_match_q && name_out_ok;
          len_d       = (len_q == ble_pkg::NAME_LEN_MAX) ? len_q : len_q + 1'b1;
        end else if (mode_q == MODE_INT && is_digit) begin
          ovf_d = ovf_q || (|acc_times10[ble_pkg::ACC_EXT_BITS-1:ble_pkg::VALUE_BITS]);
          acc_d = acc_times10[ble_pkg::VALUE_BITS-1:0];
        end else begin
          // close the pending token, then treat the character as fresh
          entry.a_valid = (mode_q != MODE_IDLE);
          mode_d        = MODE_IDLE;
          in_match_d    = 1'b0;
          out_match_d   = 1'b0;
          len_d         = '0;
          acc_d         = '0;
          ovf_d         = 1'b0;
          if (is_space) begin
            mode_d = MODE_IDLE;
          end else if (is_alpha) begin
            mode_d      = MODE_NAME;
            start_d     = cnt_q;
            in_match_d  = (char_code_i == ble_pkg::kw_input_char(3'd0));
            out_match_d = (char_code_i == ble_pkg::kw_output_char(3'd0));
            len_d       = 3'd1;
          end else if (is_digit) begin
            mode_d  = MODE_INT;
            start_d = cnt_q;
            acc_d   = ble_pkg::VALUE_BITS'(digit);
          end else begin
            entry.b_valid = 1'b1;
          end
        end
      end
    end
  end

  assign push_o      = accept && (entry.a_valid || entry.b_valid);
  assign push_data_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      in_match_q  <= 1'b0;
      out_match_q <= 1'b0;
      len_q       <= '0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
      start_q     <= '0;
    end else begin
      mode_q      <= mode_d;
      in_match_q  <= in_match_d;
      out_match_q <= out_match_d;
      len_q       <= len_d;
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      cnt_q       <= cnt_d;
      start_q     <= start_d;
    end
  end

endmodule

/* src/ble_queue.sv */
// Small token-entry queue between the front end and the output stage.
// Depends on ble_pkg for the entry type and depth.
module ble_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ble_pkg::tok_entry_t push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output ble_pkg::tok_entry_t head_o
);

  ble_pkg::tok_entry_t                mem_q [ble_pkg::QUEUE_DEPTH];
  logic [ble_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [ble_pkg::QUEUE_CNT_BITS-1:0] count_q;
  logic                               do_pop;

  assign full_o  = (count_q == ble_pkg::QUEUE_CNT_BITS'(ble_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("queue written while full");

  a_count_tracks_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not advance on push");
`endif

endmodule

/* src/ble_back.sv */
// Output stage: takes queue entries and delivers their tokens one per cycle while out_ready_i is high.
// Depends on ble_pkg; reads from ble_queue.
module ble_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  ble_pkg::tok_entry_t q_head_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [3:0]          token_kind_o,
  output logic [31:0]         int_value_o,
  output logic                overflowed_o,
  output logic [15:0]         token_start_o,
  output logic                is_end_o,
  output logic                last_o
);

  ble_pkg::tok_entry_t cur_q, cur_d;
  logic                cur_valid_q, cur_valid_d;
  logic                sel_b_q, sel_b_d;
  logic                fire, entry_done, load;
  logic [63:0]         value_wide;
  logic [31:0]         start_wide;

  assign fire       = cur_valid_q && out_ready_i;
  assign entry_done = fire && (sel_b_q || !cur_q.b_valid);
  assign load       = !cur_valid_q || entry_done;
  assign q_pop_o    = load && q_valid_i;

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    sel_b_d     = sel_b_q;
    if (load) begin
      cur_valid_d = q_valid_i;
      cur_d       = q_head_i;
      sel_b_d     = !q_head_i.a_valid;
    end else if (fire) begin
      // first token taken, second follows
      sel_b_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      sel_b_q     <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      sel_b_q     <= sel_b_d;
    end
  end

  assign value_wide = 64'(cur_q.a_value);
  assign start_wide = sel_b_q ? 32'(cur_q.b_start) : 32'(cur_q.a_start);

  assign out_valid_o   = cur_valid_q;
  assign token_kind_o  = sel_b_q ? cur_q.b_kind : cur_q.a_kind;
  assign int_value_o   = sel_b_q ? 32'd0 : value_wide[31:0];
  assign overflowed_o  = sel_b_q ? 1'b0 : cur_q.a_ovf;
  assign token_start_o = start_wide[15:0];
  assign is_end_o      = sel_b_q && cur_q.b_end;
  assign last_o        = sel_b_q || !cur_q.b_valid;

`ifndef SYNTHESIS
  a_second_token_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid_q && sel_b_q) |-> cur_q.b_valid)
    else $error("second token shown without one queued");

  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> (out_valid_o && sel_b_q))
    else $error("second token of a pair lost");
`endif

endmodule

/* src/boolean_expression_lexer.sv */
// Top level of the boolean expression lexer: front end, entry queue, output stage.
// Depends on ble_pkg, ble_front, ble_queue and ble_back.
//
//   channel | handshake               | payload
//   --------+-------------------------+---------------------------------------------
//   in      | in_valid_i / in_ready_o | char_code_i, end_of_input_i
//   out     | out_valid_o/out_ready_i | token_kind_o, int_value_o, overflowed_o,
//           |                         | token_start_o, is_end_o, last_o
//
// One character is accepted per cycle while the four-entry queue has room.
// A character that closes a token and gives one of its own yields two tokens
// from one queue entry, and the output port shows them one after the other.
// The first token of a character is written into the queue entry and then
// loaded into the output stage's current-entry register before it is offered.
// Reset clears all scan state and the queue at once; no clearing pass.
// A stalled output fills the queue, after which in_ready_o drops.
module boolean_expression_lexer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  token_kind_o,
  output logic [31:0] int_value_o,
  output logic        overflowed_o,
  output logic [15:0] token_start_o,
  output logic        is_end_o,
  output logic        last_o
);

  logic                push, full, pop, q_valid;
  ble_pkg::tok_entry_t push_data, head;

  ble_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_code_i    (char_code_i),
    .end_of_input_i (end_of_input_i),
    .queue_full_i   (full),
    .push_o         (push),
    .push_data_o    (push_data)
  );

  ble_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  ble_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_head_i      (head),
    .q_pop_o       (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .token_kind_o  (token_kind_o),
    .int_value_o   (int_value_o),
    .overflowed_o  (overflowed_o),
    .token_start_o (token_start_o),
    .is_end_o      (is_end_o),
    .last_o        (last_o)
  );

endmodule
